// ===== design/sbwc_pkg.sv =====
`default_nettype none

package sbwc_pkg;

    // Geometry of a card block and of the request and result fields.
    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned BLK_W       = 32;
    localparam int unsigned OFF_W       = 9;
    localparam int unsigned LEN_W       = 10;
    localparam int unsigned WIN_W       = 2;
    localparam int unsigned S_TDATA_W   = 56;
    localparam int unsigned M_TDATA_W   = 56;

    // Microprogram store.
    localparam int unsigned UPC_W     = 5;
    localparam int unsigned UPROG_LEN = 26;

    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [WIN_W-1:0] win_t;

    localparam win_t WIN_READ = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_SYNC,
        OP_PREFETCH
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_SERVE_READ,
        ACT_SERVE_WRITE,
        ACT_FILL,
        ACT_DIRECT,
        ACT_COPY,
        ACT_WRITEBACK,
        ACT_NONE
    } action_t;

    // Window selection relative to the active write window.
    typedef enum logic [1:0] {
        WS_ZERO,
        WS_ACTIVE,
        WS_OTHER,
        WS_READ
    } wsel_t;

    // Source of the card block field.
    typedef enum logic [1:0] {
        CB_ZERO,
        CB_REQ,
        CB_TAG
    } csel_t;

    // State update done when a step completes.
    typedef enum logic [1:0] {
        UP_NONE,
        UP_TOGGLE,
        UP_SET_TAG
    } upd_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_HIT_A,
        C_HIT_O,
        C_HIT_R,
        C_FULL,
        C_NVALID_A,
        C_NVALID_O,
        C_NPREV_IN_R,
        C_ACT_IN_R
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic    emit;
        logic    last;
        action_t act;
        wsel_t   win;
        wsel_t   src;
        csel_t   card;
        logic    serve;
        upd_t    upd;
        cond_t   cond;
        upc_t    target;
    } uword_t;

    // Status of the cache seen by the sequencer.
    typedef struct packed {
        logic hit_a;
        logic hit_o;
        logic hit_r;
        logic full;
        logic valid_a;
        logic valid_o;
        logic prev_in_r;
        logic act_in_r;
    } flags_t;

    // Entry points and jump labels of the microprogram.
    localparam upc_t UPC_READ     = 5'd0;
    localparam upc_t L_RD_SRV_R   = 5'd5;
    localparam upc_t L_RD_SRV_A   = 5'd6;
    localparam upc_t L_RD_SRV_O   = 5'd7;
    localparam upc_t L_RD_DIRECT  = 5'd8;
    localparam upc_t UPC_WRITE    = 5'd9;
    localparam upc_t L_WR_COPY    = 5'd14;
    localparam upc_t L_WR_PREV    = 5'd15;
    localparam upc_t L_WR_SERVE   = 5'd18;
    localparam upc_t UPC_SYNC     = 5'd19;
    localparam upc_t L_SY_WB_CP   = 5'd22;
    localparam upc_t L_SY_NONE    = 5'd24;
    localparam upc_t UPC_PREFETCH = 5'd25;

    function automatic uword_t mk(input logic emit, input logic last, input action_t act,
                                  input wsel_t win, input wsel_t src, input csel_t card,
                                  input logic serve, input upd_t upd, input cond_t cond,
                                  input upc_t target);
        uword_t w;
        w.emit   = emit;
        w.last   = last;
        w.act    = act;
        w.win    = win;
        w.src    = src;
        w.card   = card;
        w.serve  = serve;
        w.upd    = upd;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // A step that only tests a condition.
    function automatic uword_t br(input cond_t cond, input upc_t target);
        return mk(1'b0, 1'b0, ACT_NONE, WS_ZERO, WS_ZERO, CB_ZERO, 1'b0, UP_NONE,
                  cond, target);
    endfunction

    // A step that sends one action.
    function automatic uword_t em(input logic last, input action_t act, input wsel_t win,
                                  input wsel_t src, input csel_t card, input logic serve,
                                  input upd_t upd);
        return mk(1'b1, last, act, win, src, card, serve, upd, C_NEVER, '0);
    endfunction

    // The microprogram.
    function automatic uword_t uprog_rom(input upc_t pc);
        uword_t w;
        case (pc)
            // Read: write windows first, then the read window.
            5'd0:  w = br(C_HIT_A, L_RD_SRV_A);
            5'd1:  w = br(C_HIT_O, L_RD_SRV_O);
            5'd2:  w = br(C_HIT_R, L_RD_SRV_R);
            5'd3:  w = br(C_FULL, L_RD_DIRECT);
            5'd4:  w = em(1'b0, ACT_FILL, WS_READ, WS_ZERO, CB_REQ, 1'b0, UP_SET_TAG);
            5'd5:  w = em(1'b1, ACT_SERVE_READ, WS_READ, WS_ZERO, CB_ZERO, 1'b1, UP_NONE);
            5'd6:  w = em(1'b1, ACT_SERVE_READ, WS_ACTIVE, WS_ZERO, CB_ZERO, 1'b1, UP_NONE);
            5'd7:  w = em(1'b1, ACT_SERVE_READ, WS_OTHER, WS_ZERO, CB_ZERO, 1'b1, UP_NONE);
            5'd8:  w = em(1'b1, ACT_DIRECT, WS_ZERO, WS_ZERO, CB_REQ, 1'b1, UP_NONE);
            // Write: on a miss switch windows, load the new one, retire the old one.
            5'd9:  w = br(C_HIT_A, L_WR_SERVE);
            5'd10: w = mk(1'b0, 1'b0, ACT_NONE, WS_ZERO, WS_ZERO, CB_ZERO, 1'b0,
                          UP_TOGGLE, C_NEVER, '0);
            5'd11: w = br(C_HIT_A, L_WR_PREV);
            5'd12: w = br(C_HIT_R, L_WR_COPY);
            5'd13: w = mk(1'b1, 1'b0, ACT_FILL, WS_ACTIVE, WS_ZERO, CB_REQ, 1'b0,
                          UP_SET_TAG, C_ALWAYS, L_WR_PREV);
            5'd14: w = em(1'b0, ACT_COPY, WS_ACTIVE, WS_READ, CB_ZERO, 1'b0, UP_SET_TAG);
            5'd15: w = br(C_NVALID_O, L_WR_SERVE);
            5'd16: w = mk(1'b1, 1'b0, ACT_WRITEBACK, WS_OTHER, WS_ZERO, CB_TAG, 1'b0,
                          UP_NONE, C_NPREV_IN_R, L_WR_SERVE);
            5'd17: w = em(1'b0, ACT_COPY, WS_READ, WS_OTHER, CB_ZERO, 1'b0, UP_NONE);
            5'd18: w = em(1'b1, ACT_SERVE_WRITE, WS_ACTIVE, WS_ZERO, CB_ZERO, 1'b1, UP_NONE);
            // Sync of the active write window.
            5'd19: w = br(C_NVALID_A, L_SY_NONE);
            5'd20: w = br(C_ACT_IN_R, L_SY_WB_CP);
            5'd21: w = em(1'b1, ACT_WRITEBACK, WS_ACTIVE, WS_ZERO, CB_TAG, 1'b0, UP_NONE);
            5'd22: w = em(1'b0, ACT_WRITEBACK, WS_ACTIVE, WS_ZERO, CB_TAG, 1'b0, UP_NONE);
            5'd23: w = em(1'b1, ACT_COPY, WS_READ, WS_ACTIVE, CB_ZERO, 1'b0, UP_NONE);
            5'd24: w = em(1'b1, ACT_NONE, WS_ZERO, WS_ZERO, CB_ZERO, 1'b0, UP_NONE);
            // Prefetch into the read window.
            5'd25: w = em(1'b1, ACT_FILL, WS_READ, WS_ZERO, CB_REQ, 1'b0, UP_SET_TAG);
            default: w = mk(1'b0, 1'b1, ACT_NONE, WS_ZERO, WS_ZERO, CB_ZERO, 1'b0,
                            UP_NONE, C_NEVER, '0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/sbwc_useq.sv =====
`default_nettype none

module sbwc_useq
    import sbwc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire opcode_t start_op,
    input  wire logic    slot_free,
    input  wire flags_t  flags,
    output logic         busy,
    output logic         fire,
    output uword_t       uword
);

    logic busy_reg, busy_next;
    upc_t pc_reg, pc_next;
    logic take;
    upc_t entry;

    // Control word of the current step.
    assign uword = uprog_rom(pc_reg);
    assign busy  = busy_reg;

    // A step completes at once unless it must wait for the output register.
    assign fire = busy_reg && (!uword.emit || slot_free);

    // Jump condition select.
    always_comb
    begin
        case (uword.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_HIT_A:      take = flags.hit_a;
            C_HIT_O:      take = flags.hit_o;
            C_HIT_R:      take = flags.hit_r;
            C_FULL:       take = flags.full;
            C_NVALID_A:   take = !flags.valid_a;
            C_NVALID_O:   take = !flags.valid_o;
            C_NPREV_IN_R: take = !flags.prev_in_r;
            C_ACT_IN_R:   take = flags.act_in_r;
            default:      take = 1'b0;
        endcase
    end

    // Dispatch on the request opcode.
    always_comb
    begin
        case (start_op)
            OP_READ:     entry = UPC_READ;
            OP_WRITE:    entry = UPC_WRITE;
            OP_SYNC:     entry = UPC_SYNC;
            OP_PREFETCH: entry = UPC_PREFETCH;
            default:     entry = UPC_READ;
        endcase
    end

    // Step counter and run flag.
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = entry;
        end
        else if (fire)
        begin
            if (uword.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = take ? uword.target : pc_reg + upc_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

`ifndef SYNTHESIS
    // The step counter never leaves the program while running.
    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(pc_reg) < UPROG_LEN))
        else $error("step counter outside the microprogram");
`endif

endmodule

`default_nettype wire

// ===== design/sd_block_window_cache_policy_core.sv =====
`default_nettype none

// Channel   Group                          Contents
// request   s_tvalid s_tready s_tdata      tdata: block_number, byte_offset,
//           s_tuser                        request_length; tuser: opcode
// action    m_tvalid m_tready m_tdata      tdata: window, source_window, card_block,
//           m_tuser m_tlast                served_offset, served_length; tuser: action
//
// A request is taken only while the sequencer is idle; each request then runs
// 1 to 9 microprogram steps, one step a cycle while no action step waits for
// the output register (a prefetch is the shortest, a write miss the longest).
// A step that sends an action waits while the output register is full and
// m_tready is low. Reset empties all windows and makes window 0 active.
module sd_block_window_cache_policy_core
    import sbwc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] block_number, [40:32] byte_offset, [50:41] request_length
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] window, [3:2] source_window, [35:4] card_block,
    // [44:36] served_offset, [54:45] served_length
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [2:0] action
    output logic [2:0]                m_tuser,
    output logic                      m_tlast
);

    logic             accept;
    logic             busy;
    logic             fire;
    logic             emit_fire;
    logic             slot_free;
    uword_t           uword;
    flags_t           flags;

    logic [BLK_W-1:0] in_blk;
    logic [OFF_W-1:0] in_off;
    logic [LEN_W-1:0] in_len;
    logic [LEN_W-1:0] room;
    logic [LEN_W-1:0] clamped;

    logic [BLK_W-1:0] blk_reg;
    logic [OFF_W-1:0] off_reg;
    logic [LEN_W-1:0] len_reg;

    logic [BLK_W-1:0] tag_reg [3];
    logic [2:0]       valid_reg, valid_next;
    logic             active_reg, active_next;

    logic [2:0]       hit;
    logic             eq0r, eq1r;
    win_t             win_idx, src_idx;
    logic [BLK_W-1:0] card_val;

    logic             out_valid_reg, out_valid_next;
    action_t          out_act_reg;
    win_t             out_win_reg, out_src_reg;
    logic [BLK_W-1:0] out_card_reg;
    logic [OFF_W-1:0] out_off_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_last_reg;

    // Request beat unpacking and length clamp.
    assign in_blk  = s_tdata[BLK_W-1:0];
    assign in_off  = s_tdata[BLK_W+OFF_W-1:BLK_W];
    assign in_len  = s_tdata[BLK_W+OFF_W+LEN_W-1:BLK_W+OFF_W];
    assign room    = (32'(in_off) >= BLOCK_BYTES) ? '0
                   : LEN_W'(BLOCK_BYTES) - LEN_W'(in_off);
    assign clamped = (in_len > room) ? room : in_len;

    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign emit_fire = fire && uword.emit;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg <= in_blk;
            off_reg <= in_off;
            len_reg <= clamped;
        end
    end

    // Tag compares, one per window, plus the write windows against the read window.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hit[i] = valid_reg[i] && (tag_reg[i] == blk_reg);
        end
    end
    assign eq0r = tag_reg[0] == tag_reg[2];
    assign eq1r = tag_reg[1] == tag_reg[2];

    // Status for the sequencer, relative to the active write window.
    always_comb
    begin
        flags.hit_a     = active_reg ? hit[1] : hit[0];
        flags.hit_o     = active_reg ? hit[0] : hit[1];
        flags.hit_r     = hit[2];
        flags.full      = len_reg == LEN_W'(BLOCK_BYTES);
        flags.valid_a   = active_reg ? valid_reg[1] : valid_reg[0];
        flags.valid_o   = active_reg ? valid_reg[0] : valid_reg[1];
        flags.prev_in_r = valid_reg[2] && (active_reg ? eq0r : eq1r);
        flags.act_in_r  = valid_reg[2] && (active_reg ? eq1r : eq0r);
    end

    sbwc_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .start_op  (opcode_t'(s_tuser)),
        .slot_free (slot_free),
        .flags     (flags),
        .busy      (busy),
        .fire      (fire),
        .uword     (uword)
    );

    // Resolve the window selections of the current step.
    always_comb
    begin
        case (uword.win)
            WS_ZERO:   win_idx = '0;
            WS_ACTIVE: win_idx = {1'b0, active_reg};
            WS_OTHER:  win_idx = {1'b0, !active_reg};
            WS_READ:   win_idx = WIN_READ;
            default:   win_idx = '0;
        endcase
        case (uword.src)
            WS_ZERO:   src_idx = '0;
            WS_ACTIVE: src_idx = {1'b0, active_reg};
            WS_OTHER:  src_idx = {1'b0, !active_reg};
            WS_READ:   src_idx = WIN_READ;
            default:   src_idx = '0;
        endcase
    end

    // Card block of the action: the request's block, the tag of the target window, or zero.
    always_comb
    begin
        case (uword.card)
            CB_REQ:  card_val = blk_reg;
            CB_TAG:
            begin
                case (win_idx)
                    2'd0:    card_val = tag_reg[0];
                    2'd1:    card_val = tag_reg[1];
                    default: card_val = tag_reg[2];
                endcase
            end
            default: card_val = '0;
        endcase
    end

    // Window state updates when a step completes.
    always_comb
    begin
        valid_next  = valid_reg;
        active_next = active_reg;
        if (fire)
        begin
            case (uword.upd)
                UP_TOGGLE:  active_next = !active_reg;
                UP_SET_TAG:
                begin
                    case (win_idx)
                        2'd0:    valid_next[0] = 1'b1;
                        2'd1:    valid_next[1] = 1'b1;
                        default: valid_next[2] = 1'b1;
                    endcase
                end
                default:    active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (uword.upd == UP_SET_TAG))
        begin
            case (win_idx)
                2'd0:    tag_reg[0] <= blk_reg;
                2'd1:    tag_reg[1] <= blk_reg;
                default: tag_reg[2] <= blk_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
    end

    // Output register: loaded by an action step, emptied when the beat is taken.
    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_act_reg  <= uword.act;
            out_win_reg  <= win_idx;
            out_src_reg  <= src_idx;
            out_card_reg <= card_val;
            out_off_reg  <= uword.serve ? off_reg : '0;
            out_len_reg  <= uword.serve ? len_reg : '0;
            out_last_reg <= uword.last;
        end
    end

    // Action beat packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_len_reg, out_off_reg, out_card_reg, out_src_reg,
                       out_win_reg};

`ifndef SYNTHESIS
    // A request beat starts the sequencer.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request taken but sequencer not running");

    // The final step of a program returns the sequencer to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uword.last) |=> !busy)
        else $error("sequencer still running after its final step");

    // A write is always served from a valid active window.
    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (uword.act == ACT_SERVE_WRITE)) |->
            (active_reg ? valid_reg[1] : valid_reg[0]))
        else $error("write served from an empty window");

    // A copy never has the same window as source and target.
    a_copy_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_act_reg == ACT_COPY)) |-> (out_win_reg != out_src_reg))
        else $error("copy onto its own source window");
`endif

endmodule

`default_nettype wire

// ===== sim/sd_block_window_cache_policy_core_tb.sv =====
`timescale 1ns / 1ps

module sd_block_window_cache_policy_core_tb;
    import sbwc_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES    = 30;

    // One action beat as it leaves the block.
    typedef struct packed {
        action_t     act;
        win_t        win;
        win_t        src;
        logic [31:0] card;
        logic [8:0]  off;
        logic [9:0]  len;
        logic        last;
    } action_beat_t;

    // Window policy predictor and the queue of actions it has promised.
    class action_scoreboard;
        logic [31:0]  win_tag [3];
        bit           win_valid [3];
        bit           active_win;
        action_beat_t expected_actions [$];
        action_beat_t held;
        bit           have_held;
        int           mismatch_count;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                win_tag[i]   = '0;
                win_valid[i] = 1'b0;
            end
            active_win     = 1'b0;
            have_held      = 1'b0;
            mismatch_count = 0;
        endfunction

        function bit holds(win_t w, logic [31:0] blk);
            return win_valid[w] && (win_tag[w] == blk);
        endfunction

        // Actions are held back by one so that the final one can be marked.
        function void plan(action_t act, win_t w, win_t src, logic [31:0] card,
                           logic [8:0] off, logic [9:0] len);
            if (have_held)
                expected_actions.push_back(held);
            held.act  = act;
            held.win  = w;
            held.src  = src;
            held.card = card;
            held.off  = off;
            held.len  = len;
            held.last = 1'b0;
            have_held = 1'b1;
        endfunction

        function void note_request(opcode_t op, logic [31:0] blk, logic [8:0] off,
                                   logic [9:0] req_len);
            logic [9:0] room;
            logic [9:0] len;
            win_t       act_w;
            win_t       oth_w;
            win_t       prev_w;
            room  = 10'(BLOCK_BYTES) - {1'b0, off};
            len   = (req_len > room) ? room : req_len;
            act_w = {1'b0, active_win};
            oth_w = {1'b0, ~active_win};
            case (op)
                OP_READ:
                begin
                    if (holds(act_w, blk))
                        plan(ACT_SERVE_READ, act_w, '0, '0, off, len);
                    else if (holds(oth_w, blk))
                        plan(ACT_SERVE_READ, oth_w, '0, '0, off, len);
                    else if (!holds(WIN_READ, blk) && len == 10'(BLOCK_BYTES))
                        // A whole-block miss goes straight from the card.
                        plan(ACT_DIRECT, '0, '0, blk, off, len);
                    else
                    begin
                        if (!holds(WIN_READ, blk))
                        begin
                            win_tag[WIN_READ]   = blk;
                            win_valid[WIN_READ] = 1'b1;
                            plan(ACT_FILL, WIN_READ, '0, blk, '0, '0);
                        end
                        plan(ACT_SERVE_READ, WIN_READ, '0, '0, off, len);
                    end
                end
                OP_WRITE:
                begin
                    if (!holds(act_w, blk))
                    begin
                        // Switch windows, load the new one, retire the old one.
                        prev_w     = act_w;
                        active_win = ~active_win;
                        act_w      = {1'b0, active_win};
                        if (!holds(act_w, blk))
                        begin
                            if (holds(WIN_READ, blk))
                                plan(ACT_COPY, act_w, WIN_READ, '0, '0, '0);
                            else
                                plan(ACT_FILL, act_w, '0, blk, '0, '0);
                            win_tag[act_w]   = blk;
                            win_valid[act_w] = 1'b1;
                        end
                        if (win_valid[prev_w])
                        begin
                            plan(ACT_WRITEBACK, prev_w, '0, win_tag[prev_w], '0, '0);
                            if (holds(WIN_READ, win_tag[prev_w]))
                                plan(ACT_COPY, WIN_READ, prev_w, '0, '0, '0);
                        end
                    end
                    plan(ACT_SERVE_WRITE, act_w, '0, '0, off, len);
                end
                OP_SYNC:
                begin
                    if (win_valid[act_w])
                    begin
                        plan(ACT_WRITEBACK, act_w, '0, win_tag[act_w], '0, '0);
                        if (holds(WIN_READ, win_tag[act_w]))
                            plan(ACT_COPY, WIN_READ, act_w, '0, '0, '0);
                    end
                    else
                        plan(ACT_NONE, '0, '0, '0, '0, '0);
                end
                default:
                begin
                    win_tag[WIN_READ]   = blk;
                    win_valid[WIN_READ] = 1'b1;
                    plan(ACT_FILL, WIN_READ, '0, blk, '0, '0);
                end
            endcase
            held.last = 1'b1;
            expected_actions.push_back(held);
            have_held = 1'b0;
        endfunction

        function void check_action(action_beat_t got);
            action_beat_t want;
            if (expected_actions.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected action beat act=%0d win=%0d src=%0d card=%h off=%0d len=%0d last=%0b",
                             $realtime, got.act, got.win, got.src, got.card, got.off,
                             got.len, got.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_actions.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: action beat differs", $realtime);
                        $display("    expected act=%0d win=%0d src=%0d card=%h off=%0d len=%0d last=%0b",
                                 want.act, want.win, want.src, want.card, want.off,
                                 want.len, want.last);
                        $display("    actual   act=%0d win=%0d src=%0d card=%h off=%0d len=%0d last=%0b",
                                 got.act, got.win, got.src, got.card, got.off,
                                 got.len, got.last);
                    end
                    mismatch_count++;
                end
            end
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    int unsigned          idle_pct = 0;
    int unsigned          stall_pct = 0;
    bit                   hold_request = 1'b0;

    action_scoreboard     sb = new();

    sd_block_window_cache_policy_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #2000000;
        $display("sd_block_window_cache_policy_core: mismatch");
        $finish;
    end

    // Beats on both sides are taken at the edge, before any update of that edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(opcode_t'(s_tuser), s_tdata[31:0], s_tdata[40:32],
                            s_tdata[50:41]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_action('{act: action_t'(m_tuser), win: m_tdata[1:0],
                              src: m_tdata[3:2], card: m_tdata[35:4],
                              off: m_tdata[44:36], len: m_tdata[54:45],
                              last: m_tlast});
    end

    // Receiver: random stalls, or a long hold-off when one is asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (int i = 1; i < HOLD_OFF_CYCLES; i++)
                    @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request beat, with random idle cycles in front of it.
    task automatic send_request(opcode_t op, logic [31:0] blk, logic [8:0] off,
                                logic [9:0] len);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, len, off, blk};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random requests over a small set of blocks so that windows hit often.
    task automatic send_random(int count);
        logic [31:0] pool [6];
        opcode_t     op;
        logic [31:0] blk;
        logic [8:0]  off;
        logic [9:0]  len;
        int unsigned pick;
        pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                 32'h8000_0000, 32'h5A5A_A5A5};
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                op = OP_READ;
            else if (pick < 70)
                op = OP_WRITE;
            else if (pick < 85)
                op = OP_SYNC;
            else
                op = OP_PREFETCH;
            if ($urandom_range(99) < 85)
                blk = pool[$urandom_range(5)];
            else
                blk = $urandom;
            pick = $urandom_range(99);
            if (pick < 20)
                off = '0;
            else if (pick < 30)
                off = 9'd511;
            else
                off = 9'($urandom_range(511));
            pick = $urandom_range(99);
            if (pick < 25)
                len = 10'(BLOCK_BYTES);
            else if (pick < 35)
                len = '0;
            else
                len = 10'($urandom_range(BLOCK_BYTES));
            send_request(op, blk, off, len);
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with no idling on either side.
        idle_pct  = 0;
        stall_pct = 0;
        send_request(OP_SYNC,     32'h0000_0000, 9'd0,   10'd0);   // sync of an empty window
        send_request(OP_READ,     32'h0000_0000, 9'd0,   10'd512); // direct card read
        send_request(OP_READ,     32'hFFFF_FFFF, 9'd511, 10'd512); // clamped to one byte
        send_request(OP_READ,     32'hFFFF_FFFF, 9'd0,   10'd0);   // read window hit
        send_request(OP_PREFETCH, 32'h0000_0005, 9'd0,   10'd0);
        send_request(OP_WRITE,    32'h0000_0005, 9'd100, 10'd512); // copy from read window
        send_request(OP_WRITE,    32'h0000_0007, 9'd0,   10'd1);   // fill, write back, copy
        send_request(OP_WRITE,    32'h0000_0005, 9'd3,   10'd9);   // other window holds it
        send_request(OP_READ,     32'h0000_0007, 9'd10,  10'd20);  // hit in other window
        send_request(OP_READ,     32'h0000_0005, 9'd0,   10'd512); // hit in active window
        send_request(OP_SYNC,     32'h0000_0000, 9'd0,   10'd0);   // write back and copy
        send_request(OP_PREFETCH, 32'h0000_0009, 9'd0,   10'd0);
        send_request(OP_SYNC,     32'h0000_0000, 9'd0,   10'd0);   // write back only
        send_request(OP_WRITE,    32'hFFFF_FFFE, 9'd511, 10'd512);
        send_request(OP_READ,     32'hFFFF_FFFE, 9'd0,   10'd512); // full length but a hit
        send_request(OP_READ,     32'h0000_0003, 9'd1,   10'd512); // clamp avoids direct read
        send_request(OP_READ,     32'h0000_0003, 9'd0,   10'd512); // full length, read hit
        send_request(OP_WRITE,    32'h0000_0000, 9'd0,   10'd0);
        send_request(OP_READ,     32'h1234_5678, 9'd256, 10'd256);
        send_request(OP_PREFETCH, 32'hFFFF_FFFF, 9'd0,   10'd0);
        send_request(OP_WRITE,    32'hFFFF_FFFF, 9'd511, 10'd0);
        send_request(OP_WRITE,    32'hA5A5_5A5A, 9'd170, 10'd341);

        // Random requests under each idling pattern.
        send_random(78);
        idle_pct  = 51;
        stall_pct = 0;
        send_random(78);
        idle_pct  = 0;
        stall_pct = 51;
        send_random(78);
        idle_pct  = 21;
        stall_pct = 21;
        send_random(78);

        // Receiver holds off while requests keep coming, so the block backs up.
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        send_random(16);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("sd_block_window_cache_policy_core: match");
        else
            $display("sd_block_window_cache_policy_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sbwc_pkg.sv
design/sbwc_useq.sv
design/sd_block_window_cache_policy_core.sv
sim/sd_block_window_cache_policy_core_tb.sv
